FILE: rtl/mcbm_pkg.sv
// shared types and constants for the multi-channel byte mailbox
// no dependencies
package mcbm_pkg;

  localparam int BOX_COUNT   = 16;
  localparam int RING_BYTES  = 64;
  localparam int MAX_RESULTS = 64;
  localparam int BOX_W       = $clog2(BOX_COUNT);
  localparam int POS_W       = $clog2(RING_BYTES);
  localparam int FILL_W      = $clog2(RING_BYTES + 1);
  localparam int ADDR_W      = BOX_W + POS_W;

  typedef enum logic [1:0] {
    KIND_OPEN  = 2'd0,
    KIND_CLOSE = 2'd1,
    KIND_SEND  = 2'd2,
    KIND_RECV  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_USED  = 2'd1,
    ST_WOULD_BLK = 2'd2,
    ST_NO_FREE   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_RECV,
    S_RESP
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic capture;      // latch input transaction
    logic scan_clear;   // reset scan index
    logic scan_step;    // advance scan index
    logic do_close;
    logic do_claim;     // claim first free box found by the scan, if no name matched
    logic do_send;      // apply send result
    logic recv_start;   // set up receive run
    logic recv_step;    // issue one memory read
    logic emit_single;  // present single result
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    kind_t kind;
    logic  scan_done;
    logic  recv_last;   // last read issued
    logic  recv_run;    // receive will emit bytes
  } dp_stat_t;

endpackage

FILE: rtl/mcbm_ctrl.sv
// controller state machine for the mailbox
// depends on mcbm_pkg
module mcbm_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  mcbm_pkg::dp_stat_t  stat,
  output mcbm_pkg::dp_cmd_t   cmd
);

  mcbm_pkg::state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= mcbm_pkg::S_IDLE;
    else        state_r <= state_nxt;
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    case (state_r)
      mcbm_pkg::S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.capture = 1'b1;
          state_nxt   = mcbm_pkg::S_DECODE;
        end
      end
      mcbm_pkg::S_DECODE: begin
        case (stat.kind)
          mcbm_pkg::KIND_OPEN: begin
            cmd.scan_clear = 1'b1;
            state_nxt      = mcbm_pkg::S_SCAN;
          end
          mcbm_pkg::KIND_CLOSE: begin
            cmd.do_close    = 1'b1;
            cmd.emit_single = 1'b1;
            state_nxt       = mcbm_pkg::S_IDLE;
          end
          mcbm_pkg::KIND_SEND: begin
            cmd.do_send     = 1'b1;
            cmd.emit_single = 1'b1;
            state_nxt       = mcbm_pkg::S_IDLE;
          end
          default: begin
            cmd.recv_start = 1'b1;
            if (stat.recv_run) state_nxt = mcbm_pkg::S_RECV;
            else begin
              cmd.emit_single = 1'b1;
              state_nxt       = mcbm_pkg::S_IDLE;
            end
          end
        endcase
      end
      mcbm_pkg::S_SCAN: begin
        if (stat.scan_done) begin
          cmd.do_claim    = 1'b1;
          cmd.emit_single = 1'b1;
          state_nxt       = mcbm_pkg::S_IDLE;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      mcbm_pkg::S_RECV: begin
        cmd.recv_step = 1'b1;
        if (stat.recv_last) state_nxt = mcbm_pkg::S_RESP;
      end
      mcbm_pkg::S_RESP: begin
        // last read data drains to the output
        state_nxt = mcbm_pkg::S_IDLE;
      end
      default: state_nxt = mcbm_pkg::S_IDLE;
    endcase
  end

  // assertions
  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !cmd.capture) else $error("capture while busy");
  a_claim_scan: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.do_claim |-> stat.scan_done) else $error("claim before scan done");
  a_recv_follow: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mcbm_pkg::S_RESP) |=> !busy) else $error("resp did not end");

endmodule

FILE: rtl/mcbm_dp.sv
// datapath: box table, ring memory, open scan and result registers
// depends on mcbm_pkg
module mcbm_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  mcbm_pkg::dp_cmd_t  cmd,
  output mcbm_pkg::dp_stat_t stat,
  input  logic [1:0]         in_kind,
  input  logic [4:0]         in_box,
  input  logic [15:0]        in_first_name,
  input  logic [15:0]        in_second_name,
  input  logic [6:0]         in_length,
  input  logic [7:0]         in_data_byte,
  input  logic               in_first_byte,
  input  logic               in_final_byte,
  output logic               out_strobe,
  output logic [1:0]         out_status,
  output logic [4:0]         out_box_number,
  output logic [6:0]         out_moved_count,
  output logic [7:0]         out_read_byte,
  output logic               out_byte_valid,
  output logic               out_run_end
);

  localparam int BC = mcbm_pkg::BOX_COUNT;
  localparam int BW = mcbm_pkg::BOX_W;
  localparam int PW = mcbm_pkg::POS_W;
  localparam int FW = mcbm_pkg::FILL_W;
  localparam int AW = mcbm_pkg::ADDR_W;
  localparam int SW = $clog2(BC + 1);

  // box table
  logic [BC-1:0] in_use_r;
  logic [15:0]   name1_r [BC];
  logic [15:0]   name2_r [BC];
  logic [PW-1:0] rpos_r  [BC];
  logic [PW-1:0] wpos_r  [BC];
  logic [FW-1:0] fill_r  [BC];
  logic          send_acc_r;
  logic [1:0]    send_st_r;

  // captured transaction
  logic [1:0]  kind_r;
  logic [4:0]  box_r;
  logic [15:0] n1_r, n2_r;
  logic [6:0]  len_r;
  logic [7:0]  dbyte_r;
  logic        first_r, final_r;

  // scan and receive
  logic [SW-1:0] scan_r;
  logic          found_r, free_found_r;
  logic [BW-1:0] hit_r, free_r;
  logic [6:0]    rcnt_r;
  logic [6:0]    mv_r;
  logic          rd_v_r, rd_end_r;

  // ring memory
  logic [7:0]    ring_mem [2**AW];
  logic [7:0]    rd_data_r;

  // decode of the addressed box
  logic          box_ok;
  logic [BW-1:0] bi;
  logic          live;
  assign box_ok = (box_r != 5'd0) && ({1'b0, box_r} <= 6'(BC));
  assign bi     = BW'(box_r - 5'd1);
  assign live   = box_ok && in_use_r[bi];

  logic [BW-1:0] si;
  assign si = scan_r[BW-1:0];

  assign stat.kind      = mcbm_pkg::kind_t'(kind_r);
  assign stat.scan_done = (scan_r == SW'(BC));
  assign stat.recv_last = (rcnt_r == 7'd1);
  assign stat.recv_run  = live && (len_r <= 7'(fill_r[bi])) &&
                          (len_r <= 7'(mcbm_pkg::MAX_RESULTS)) && (len_r != 7'd0);

  // send evaluation
  logic [1:0] snd_st;
  logic       snd_acc, snd_wr;
  logic [6:0] room;
  always_comb begin
    room    = 7'(mcbm_pkg::RING_BYTES) - 7'(fill_r[bi]);
    snd_st  = send_st_r;
    snd_acc = send_acc_r;
    snd_wr  = 1'b0;
    if (first_r) begin
      if (!live)             snd_st = mcbm_pkg::ST_NOT_USED;
      else if (len_r > room) snd_st = mcbm_pkg::ST_WOULD_BLK;
      else                   snd_st = mcbm_pkg::ST_OK;
      snd_acc = (snd_st == mcbm_pkg::ST_OK);
    end else if (!send_acc_r) begin
      snd_st = (send_st_r != mcbm_pkg::ST_OK) ? send_st_r : mcbm_pkg::ST_WOULD_BLK;
    end else if (!live) begin
      snd_st  = mcbm_pkg::ST_NOT_USED;
      snd_acc = 1'b0;
    end
    if (first_r || send_acc_r) begin
      if (snd_acc && live) begin
        if (fill_r[bi] >= FW'(mcbm_pkg::RING_BYTES)) begin
          snd_st  = mcbm_pkg::ST_WOULD_BLK;
          snd_acc = 1'b0;
        end else begin
          snd_wr = 1'b1;
          if (final_r) snd_acc = 1'b0;
        end
      end else begin
        snd_acc = 1'b0;
      end
    end
  end

  // capture and scan registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r  <= in_kind;
      box_r   <= in_box;
      n1_r    <= in_first_name;
      n2_r    <= in_second_name;
      len_r   <= in_length;
      dbyte_r <= in_data_byte;
      first_r <= in_first_byte;
      final_r <= in_final_byte;
    end
    if (cmd.scan_clear) begin
      scan_r       <= '0;
      found_r      <= 1'b0;
      free_found_r <= 1'b0;
    end else if (cmd.scan_step) begin
      scan_r <= scan_r + SW'(1);
      if (in_use_r[si] && !found_r &&
          (name1_r[si] == n1_r || name2_r[si] == n2_r)) begin
        found_r <= 1'b1;
        hit_r   <= si;
      end
      if (!in_use_r[si] && !free_found_r) begin
        free_found_r <= 1'b1;
        free_r       <= si;
      end
    end
  end

  // box table updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_use_r   <= '0;
      send_acc_r <= 1'b0;
      send_st_r  <= mcbm_pkg::ST_OK;
      for (int i = 0; i < BC; i++) begin
        name1_r[i] <= '0;
        name2_r[i] <= '0;
        rpos_r[i]  <= '0;
        wpos_r[i]  <= '0;
        fill_r[i]  <= '0;
      end
    end else begin
      if (cmd.do_close && live) begin
        in_use_r[bi] <= 1'b0;
        name1_r[bi]  <= '0;
        name2_r[bi]  <= '0;
        rpos_r[bi]   <= '0;
        wpos_r[bi]   <= '0;
        fill_r[bi]   <= '0;
      end
      if (cmd.do_claim && !found_r && free_found_r) begin
        in_use_r[free_r] <= 1'b1;
        name1_r[free_r]  <= n1_r;
        name2_r[free_r]  <= n2_r;
        rpos_r[free_r]   <= '0;
        wpos_r[free_r]   <= '0;
        fill_r[free_r]   <= '0;
      end
      if (cmd.do_send) begin
        send_acc_r <= snd_acc;
        send_st_r  <= snd_st;
        if (snd_wr) begin
          wpos_r[bi] <= wpos_r[bi] + PW'(1);
          fill_r[bi] <= fill_r[bi] + FW'(1);
        end
      end
      if (cmd.recv_start && stat.recv_run) fill_r[bi] <= fill_r[bi] - FW'(len_r);
      if (cmd.recv_step) rpos_r[bi] <= rpos_r[bi] + PW'(1);
    end
  end

  // ring memory, one port each way
  always_ff @(posedge clk) begin
    if (cmd.do_send && snd_wr) ring_mem[{bi, wpos_r[bi]}] <= dbyte_r;
    if (cmd.recv_step) rd_data_r <= ring_mem[{bi, rpos_r[bi]}];
  end

  // receive counter and byte result pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r <= 1'b0;
    end else begin
      rd_v_r <= cmd.recv_step;
    end
    if (cmd.recv_start) begin
      rcnt_r <= len_r;
      mv_r   <= (7'(fill_r[bi]) == len_r) ? 7'd0 : len_r;
    end else if (cmd.recv_step) begin
      rcnt_r <= rcnt_r - 7'd1;
    end
    rd_end_r <= cmd.recv_step && (rcnt_r == 7'd1);
  end

  // single result register
  logic       sgl_v_r;
  logic [1:0] sgl_st_r;
  logic [4:0] sgl_bn_r;
  logic [6:0] sgl_mv_r;
  always_ff @(posedge clk) begin
    if (!rst_n) sgl_v_r <= 1'b0;
    else        sgl_v_r <= cmd.emit_single;
    if (cmd.emit_single) begin
      sgl_bn_r <= 5'd0;
      sgl_mv_r <= 7'd0;
      case (mcbm_pkg::kind_t'(kind_r))
        mcbm_pkg::KIND_OPEN: begin
          if (found_r) begin
            sgl_st_r <= mcbm_pkg::ST_OK;
            sgl_bn_r <= 5'(hit_r) + 5'd1;
          end else if (free_found_r) begin
            sgl_st_r <= mcbm_pkg::ST_OK;
            sgl_bn_r <= 5'(free_r) + 5'd1;
          end else begin
            sgl_st_r <= mcbm_pkg::ST_NO_FREE;
          end
        end
        mcbm_pkg::KIND_CLOSE:
          sgl_st_r <= live ? mcbm_pkg::ST_OK : mcbm_pkg::ST_NOT_USED;
        mcbm_pkg::KIND_SEND: begin
          sgl_st_r <= snd_wr ? mcbm_pkg::ST_OK : snd_st;
          sgl_mv_r <= snd_wr ? 7'd1 : 7'd0;
        end
        default: begin
          if (!live) sgl_st_r <= mcbm_pkg::ST_NOT_USED;
          else if (len_r > 7'(fill_r[bi]) || len_r > 7'(mcbm_pkg::MAX_RESULTS))
            sgl_st_r <= mcbm_pkg::ST_WOULD_BLK;
          else sgl_st_r <= mcbm_pkg::ST_OK;
        end
      endcase
    end
  end

  // output mux
  assign out_strobe      = sgl_v_r | rd_v_r;
  assign out_status      = rd_v_r ? mcbm_pkg::ST_OK : sgl_st_r;
  assign out_box_number  = rd_v_r ? 5'd0 : sgl_bn_r;
  assign out_moved_count = rd_v_r ? mv_r : sgl_mv_r;
  assign out_read_byte   = rd_v_r ? rd_data_r : 8'd0;
  assign out_byte_valid  = rd_v_r;
  assign out_run_end     = rd_v_r ? rd_end_r : 1'b1;

  // assertions
  a_one_source: assert property (@(posedge clk) disable iff (!rst_n)
    !(sgl_v_r && rd_v_r)) else $error("two result sources at once");
  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.do_send |-> fill_r[bi] <= FW'(mcbm_pkg::RING_BYTES)) else $error("fill overflow");
  a_step_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.recv_step |-> rcnt_r != 7'd0) else $error("read past request");

endmodule

FILE: rtl/multi_channel_byte_mailbox.sv
// top level of the multi-channel byte mailbox
// depends on mcbm_pkg, mcbm_ctrl and mcbm_dp
//
// Raise start while busy is low to hand over one transaction. Open, close and
// send each answer with one strobed result; open first scans the box table one
// entry a cycle. A receive of n bytes that the box can serve (n nonzero, at most
// the fill and MAX_RESULTS) emits n results on consecutive cycles, one read of
// the ring memory per cycle; any other receive answers with one strobed result.
// Results show for one cycle only, the receiver must take them.
// No clearing pass is needed after reset.
module multi_channel_byte_mailbox (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_kind,
  input  logic [4:0]  in_box,
  input  logic [15:0] in_first_name,
  input  logic [15:0] in_second_name,
  input  logic [6:0]  in_length,
  input  logic [7:0]  in_data_byte,
  input  logic        in_first_byte,
  input  logic        in_final_byte,
  output logic        out_strobe,
  output logic [1:0]  out_status,
  output logic [4:0]  out_box_number,
  output logic [6:0]  out_moved_count,
  output logic [7:0]  out_read_byte,
  output logic        out_byte_valid,
  output logic        out_run_end
);

  mcbm_pkg::dp_cmd_t  cmd;
  mcbm_pkg::dp_stat_t stat;

  mcbm_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  mcbm_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_kind         (in_kind),
    .in_box          (in_box),
    .in_first_name   (in_first_name),
    .in_second_name  (in_second_name),
    .in_length       (in_length),
    .in_data_byte    (in_data_byte),
    .in_first_byte   (in_first_byte),
    .in_final_byte   (in_final_byte),
    .out_strobe      (out_strobe),
    .out_status      (out_status),
    .out_box_number  (out_box_number),
    .out_moved_count (out_moved_count),
    .out_read_byte   (out_read_byte),
    .out_byte_valid  (out_byte_valid),
    .out_run_end     (out_run_end)
  );

endmodule

FILE: tb/tb_top.sv
// self-checking testbench for the multi-channel byte mailbox
// depends on mcbm_pkg and multi_channel_byte_mailbox; a mailbox ledger class
// predicts every reply and checks the strobed results against it
module tb_top;
  import mcbm_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int ITEM_COUNT = 170;

  typedef struct {
    status_t    status;
    logic [4:0] box_number;
    logic [6:0] moved;
    logic [7:0] rbyte;
    logic       valid;
    logic       last;
  } reply_t;

  // mailbox ledger: own copy of the box table, predicted replies, checking
  class mailbox_ledger;
    bit          used [BOX_COUNT];
    logic [15:0] name_a [BOX_COUNT];
    logic [15:0] name_b [BOX_COUNT];
    int          rd_pos [BOX_COUNT];
    int          wr_pos [BOX_COUNT];
    int          fill [BOX_COUNT];
    logic [7:0]  ring [BOX_COUNT][RING_BYTES];
    bit          accepting;
    status_t     send_st;
    reply_t      pending_replies [$];
    int          mismatches;

    function new();
      for (int i = 0; i < BOX_COUNT; i++) begin
        used[i] = 0; name_a[i] = '0; name_b[i] = '0;
        rd_pos[i] = 0; wr_pos[i] = 0; fill[i] = 0;
      end
      accepting = 0;
      send_st = ST_OK;
      mismatches = 0;
    endfunction

    function int live(logic [4:0] bx);
      if (bx < 1 || bx > BOX_COUNT) return -1;
      if (!used[bx - 1]) return -1;
      return bx - 1;
    endfunction

    function void queue_reply(status_t st, int bn, int mv, logic [7:0] rb, bit vl, bit last);
      reply_t r;
      r.status = st; r.box_number = bn[4:0]; r.moved = mv[6:0];
      r.rbyte = rb; r.valid = vl; r.last = last;
      pending_replies.push_back(r);
    endfunction

    // predict the replies of one accepted transaction
    function void note_request(kind_t k, logic [4:0] bx, logic [15:0] n1, logic [15:0] n2,
                               logic [6:0] len, logic [7:0] data, bit first, bit fin);
      int b;
      int mv;
      status_t st;
      b = live(bx);
      case (k)
        KIND_OPEN: begin
          for (int i = 0; i < BOX_COUNT; i++)
            if (used[i] && (name_a[i] == n1 || name_b[i] == n2)) begin
              queue_reply(ST_OK, i + 1, 0, 0, 0, 1);
              return;
            end
          for (int i = 0; i < BOX_COUNT; i++)
            if (!used[i]) begin
              used[i] = 1; name_a[i] = n1; name_b[i] = n2;
              rd_pos[i] = 0; wr_pos[i] = 0; fill[i] = 0;
              queue_reply(ST_OK, i + 1, 0, 0, 0, 1);
              return;
            end
          queue_reply(ST_NO_FREE, 0, 0, 0, 0, 1);
        end
        KIND_CLOSE: begin
          if (b < 0) begin
            queue_reply(ST_NOT_USED, 0, 0, 0, 0, 1);
            return;
          end
          used[b] = 0; name_a[b] = '0; name_b[b] = '0;
          rd_pos[b] = 0; wr_pos[b] = 0; fill[b] = 0;
          queue_reply(ST_OK, 0, 0, 0, 0, 1);
        end
        KIND_SEND: begin
          if (first) begin
            if (b < 0) st = ST_NOT_USED;
            else if (len > RING_BYTES - fill[b]) st = ST_WOULD_BLK;
            else st = ST_OK;
            send_st = st;
            accepting = (st == ST_OK);
          end else if (!accepting) begin
            queue_reply((send_st != ST_OK) ? send_st : ST_WOULD_BLK, 0, 0, 0, 0, 1);
            return;
          end else if (b < 0) begin
            send_st = ST_NOT_USED;
            accepting = 0;
          end
          if (accepting && b >= 0) begin
            if (fill[b] >= RING_BYTES) begin
              send_st = ST_WOULD_BLK;
              accepting = 0;
            end else begin
              ring[b][wr_pos[b]] = data;
              wr_pos[b] = (wr_pos[b] + 1) % RING_BYTES;
              fill[b]++;
              if (fin) accepting = 0;
              queue_reply(ST_OK, 0, 1, 0, 0, 1);
              return;
            end
          end
          accepting = 0;
          queue_reply(send_st, 0, 0, 0, 0, 1);
        end
        default: begin
          if (b < 0) queue_reply(ST_NOT_USED, 0, 0, 0, 0, 1);
          else if (len > fill[b] || len > MAX_RESULTS)
            queue_reply(ST_WOULD_BLK, 0, 0, 0, 0, 1);
          else if (len == 0) queue_reply(ST_OK, 0, 0, 0, 0, 1);
          else begin
            mv = (fill[b] == len) ? 0 : len;
            for (int j = 0; j < len; j++) begin
              queue_reply(ST_OK, 0, mv, ring[b][rd_pos[b]], 1, j + 1 == len);
              rd_pos[b] = (rd_pos[b] + 1) % RING_BYTES;
            end
            fill[b] -= len;
          end
        end
      endcase
    endfunction

    // compare one strobed result with the oldest predicted reply
    function void check_reply(reply_t got);
      reply_t want;
      if (pending_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status %0d box %0d moved %0d byte %0h",
                   got.status, got.box_number, got.moved, got.rbyte);
        return;
      end
      want = pending_replies.pop_front();
      if (got.status !== want.status || got.box_number !== want.box_number ||
          got.moved !== want.moved || got.rbyte !== want.rbyte ||
          got.valid !== want.valid || got.last !== want.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: exp st %0d box %0d mv %0d byte %0h vl %0b end %0b",
                    " / got st %0d box %0d mv %0d byte %0h vl %0b end %0b"},
                   want.status, want.box_number, want.moved, want.rbyte, want.valid,
                   want.last, got.status, got.box_number, got.moved, got.rbyte,
                   got.valid, got.last);
      end
    endfunction
  endclass

  logic        clk, rst_n, start, busy;
  logic [1:0]  in_kind;
  logic [4:0]  in_box;
  logic [15:0] in_first_name, in_second_name;
  logic [6:0]  in_length;
  logic [7:0]  in_data_byte;
  logic        in_first_byte, in_final_byte;
  logic        out_strobe, out_byte_valid, out_run_end;
  logic [1:0]  out_status;
  logic [4:0]  out_box_number;
  logic [6:0]  out_moved_count;
  logic [7:0]  out_read_byte;

  multi_channel_byte_mailbox dut (.*);

  mailbox_ledger ledger = new();
  int     idle_pct = 19;
  int     cycles = 0;
  int     items_sent = 0;

  // clock
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // results are taken at the rising edge that ends their cycle
  always @(posedge clk) begin
    reply_t got;
    if (rst_n && out_strobe) begin
      got.status = status_t'(out_status);
      got.box_number = out_box_number;
      got.moved = out_moved_count;
      got.rbyte = out_read_byte;
      got.valid = out_byte_valid;
      got.last = out_run_end;
      ledger.check_reply(got);
    end
  end

  // hand one transaction over, with random idle cycles ahead of it
  task automatic put_item(kind_t k, logic [4:0] bx, logic [15:0] n1, logic [15:0] n2,
                          logic [6:0] len, logic [7:0] data, bit first, bit fin);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      start = 0;
      @(negedge clk);
    end
    start = 1;
    in_kind = k; in_box = bx; in_first_name = n1; in_second_name = n2;
    in_length = len; in_data_byte = data; in_first_byte = first; in_final_byte = fin;
    while (busy) @(negedge clk);
    ledger.note_request(k, bx, n1, n2, len, data, first, fin);
    items_sent++;
  endtask

  task automatic drain_replies();
    @(negedge clk);
    start = 0;
    while (ledger.pending_replies.size() != 0) @(negedge clk);
  endtask

  function automatic int pick_live();
    int tries;
    int b;
    for (tries = 0; tries < 40; tries++) begin
      b = $urandom_range(BOX_COUNT - 1);
      if (ledger.used[b]) return b + 1;
    end
    return 0;
  endfunction

  // one send message; stretch adds bytes past the declared length
  task automatic send_message(logic [4:0] bx, int len, int stretch, bit close_midway);
    int total;
    total = len + stretch;
    if (total == 0) total = 1;
    for (int i = 0; i < total; i++) begin
      if (close_midway && i == 1) put_item(KIND_CLOSE, bx, 0, 0, 0, 0, 0, 0);
      put_item(KIND_SEND, bx, 16'($urandom), 16'($urandom), len[6:0], 8'($urandom),
               i == 0, i == total - 1);
    end
  endtask

  initial begin
    int bx, len, sel, f;
    bit drained;
    logic [15:0] n1, n2;
    logic [15:0] pool [4];
    rst_n = 0; start = 0;
    in_kind = KIND_OPEN; in_box = '0; in_first_name = '0; in_second_name = '0;
    in_length = '0; in_data_byte = '0; in_first_byte = 0; in_final_byte = 0;
    drained = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed: fill the table, no free box, name matches, closes, edge sends/receives
    for (int i = 1; i <= BOX_COUNT; i++)
      put_item(KIND_OPEN, 0, 16'(32'h1000 + i), 16'(32'h2000 + i), 0, 0, 0, 0);
    put_item(KIND_OPEN, 0, 16'hFFFF, 16'hFFFF, 0, 0, 0, 0);
    put_item(KIND_OPEN, 0, 16'h1003, 16'h0000, 0, 0, 0, 0);
    put_item(KIND_OPEN, 0, 16'h0000, 16'h2007, 0, 0, 0, 0);
    put_item(KIND_CLOSE, 0, 0, 0, 0, 0, 0, 0);
    put_item(KIND_CLOSE, 5, 0, 0, 0, 0, 0, 0);
    put_item(KIND_CLOSE, 5, 0, 0, 0, 0, 0, 0);
    put_item(KIND_OPEN, 0, 16'h1005, 16'h2005, 0, 0, 0, 0);
    put_item(KIND_SEND, 16, 0, 0, 1, 8'hFF, 1, 1);
    put_item(KIND_SEND, 16, 0, 0, 64, 8'h00, 1, 0);
    put_item(KIND_SEND, 16, 0, 0, 64, 8'hA5, 0, 0);
    put_item(KIND_SEND, 0, 0, 0, 1, 8'h5A, 1, 1);
    put_item(KIND_RECV, 16, 0, 0, 2, 0, 0, 0);
    put_item(KIND_RECV, 16, 0, 0, 0, 0, 0, 0);
    put_item(KIND_RECV, 16, 0, 0, 1, 0, 0, 0);
    put_item(KIND_RECV, 0, 0, 0, 1, 0, 0, 0);

    // random: mostly well-formed messages between opens, closes and receives
    for (int i = 0; i < 4; i++) pool[i] = 16'($urandom);
    while (items_sent < ITEM_COUNT) begin
      if (idle_pct == 19 && items_sent >= ITEM_COUNT / 3) idle_pct = 84;
      if (items_sent >= 2 * ITEM_COUNT / 3) idle_pct = 0;
      if (!drained && items_sent >= ITEM_COUNT / 2) begin
        drain_replies();
        drained = 1;
      end
      sel = $urandom_range(99);
      bx = pick_live();
      if (sel < 15 || bx == 0) begin
        n1 = ($urandom_range(1) != 0) ? pool[$urandom_range(3)] : 16'($urandom);
        n2 = ($urandom_range(1) != 0) ? pool[$urandom_range(3)] : 16'($urandom);
        put_item(KIND_OPEN, 5'($urandom_range(16)), n1, n2, 7'($urandom_range(64)),
                 8'($urandom), 1'($urandom_range(1)), 1'($urandom_range(1)));
      end else if (sel < 25) begin
        put_item(KIND_CLOSE, 5'(($urandom_range(3) == 0) ? $urandom_range(16) : bx),
                 0, 0, 0, 0, 0, 0);
      end else if (sel < 60) begin
        f = RING_BYTES - ledger.fill[bx - 1];
        len = ($urandom_range(4) == 0) ? $urandom_range(64) : $urandom_range(1, 8);
        if ($urandom_range(9) == 0) send_message(5'(bx), f, 1, 0);
        else if ($urandom_range(19) == 0) send_message(5'(bx), len, 0, 1);
        else send_message(5'(bx), len, ($urandom_range(9) == 0) ? 2 : 0, 0);
      end else if (sel < 90) begin
        f = ledger.fill[bx - 1];
        case ($urandom_range(5))
          0: len = f;
          1: len = (f < 64) ? f + 1 : 64;
          2: len = 0;
          default: len = (f > 0) ? $urandom_range(1, f) : 0;
        endcase
        put_item(KIND_RECV, 5'(bx), 16'($urandom), 16'($urandom), 7'(len), 8'($urandom),
                 1'($urandom_range(1)), 1'($urandom_range(1)));
      end else begin
        put_item(kind_t'($urandom_range(3)), 5'($urandom_range(16)), 16'($urandom),
                 16'($urandom), 7'($urandom_range(64)), 8'($urandom),
                 1'($urandom_range(1)), 1'($urandom_range(1)));
      end
    end

    // wait out the last results, then a receive run's worth of cycles
    drain_replies();
    repeat (80) @(negedge clk);
    if (ledger.pending_replies.size() != 0) ledger.mismatches++;
    if (ledger.mismatches == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
